/* src/twlru_pkg.sv */
package twlru_pkg;

   localparam int PROCS        = 4;
   localparam int PAGE_BITS    = 12;
   localparam int VADDR_BITS   = 32;
   localparam int FRAME_BITS   = 8;
   localparam int MAX_DIR_BITS = 10;

   localparam int PID_IN_W  = 2;
   localparam int PADDR_W   = 20;
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_FIRST_LEVEL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_BITS  = 1'd1;

   localparam logic [CFG_W-1:0] FIRST_LEVEL_RESET = 4'd10;
   localparam logic [CFG_W-1:0] FRAME_BITS_RESET  = 4'd8;

endpackage

/* src/twlru_req_if.sv */
interface twlru_req_if #(
   parameter int VADDR_BITS = twlru_pkg::VADDR_BITS
);
   logic                              valid;
   logic                              ready;
   logic [twlru_pkg::PID_IN_W-1:0]    process_id;
   logic [VADDR_BITS-1:0]             virtual_addr;

   modport source (output valid, output process_id, output virtual_addr, input ready);
   modport sink   (input valid, input process_id, input virtual_addr, output ready);
endinterface

/* src/twlru_rsp_if.sv */
interface twlru_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            hit;
   logic                            table_created;
   logic                            evicted;
   logic [twlru_pkg::PADDR_W-1:0]   physical_addr;

   modport source (output valid, output hit, output table_created, output evicted,
                   output physical_addr, input ready);
   modport sink   (input valid, input hit, input table_created, input evicted,
                   input physical_addr, output ready);
endinterface

/* src/twlru_lru.sv */
module twlru_lru #(
   parameter int FRAME_BITS = twlru_pkg::FRAME_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  flush,
   input  logic [FRAME_BITS-1:0] nmask,
   input  logic [FRAME_BITS-1:0] nxt_raddr,
   input  logic [FRAME_BITS-1:0] prv_raddr,
   input  logic                  nxt_we,
   input  logic [FRAME_BITS-1:0] nxt_waddr,
   input  logic [FRAME_BITS-1:0] nxt_wdata,
   input  logic                  prv_we,
   input  logic [FRAME_BITS-1:0] prv_waddr,
   input  logic [FRAME_BITS-1:0] prv_wdata,
   output logic [FRAME_BITS-1:0] nxt_rdata,
   output logic [FRAME_BITS-1:0] prv_rdata
);

   localparam int NF = 1 << FRAME_BITS;

   logic [FRAME_BITS-1:0] nxt_mem [NF];
   logic [FRAME_BITS-1:0] prv_mem [NF];
   logic [NF-1:0]         nxt_vld_ff;
   logic [NF-1:0]         prv_vld_ff;

   logic [FRAME_BITS-1:0] nxt_rd_ff;
   logic [FRAME_BITS-1:0] prv_rd_ff;
   logic                  nxt_rv_ff;
   logic                  prv_rv_ff;
   logic [FRAME_BITS-1:0] nxt_ra_ff;
   logic [FRAME_BITS-1:0] prv_ra_ff;

   always_ff @(posedge clock) begin
      if (nxt_we) begin
         nxt_mem[nxt_waddr] <= nxt_wdata;
      end
      if (prv_we) begin
         prv_mem[prv_waddr] <= prv_wdata;
      end
      nxt_rd_ff <= nxt_mem[nxt_raddr];
      prv_rd_ff <= prv_mem[prv_raddr];
      nxt_ra_ff <= nxt_raddr;
      prv_ra_ff <= prv_raddr;
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         nxt_vld_ff <= '0;
         prv_vld_ff <= '0;
         nxt_rv_ff  <= 1'b0;
         prv_rv_ff  <= 1'b0;
      end else begin
         nxt_rv_ff <= nxt_vld_ff[nxt_raddr];
         prv_rv_ff <= prv_vld_ff[prv_raddr];
         if (nxt_we) begin
            nxt_vld_ff[nxt_waddr] <= 1'b1;
         end
         if (prv_we) begin
            prv_vld_ff[prv_waddr] <= 1'b1;
         end
      end
   end

   // unwritten entries follow the ring in frame order
   assign nxt_rdata = nxt_rv_ff ? nxt_rd_ff : ((nxt_ra_ff + 1'b1) & nmask);
   assign prv_rdata = prv_rv_ff ? prv_rd_ff : ((prv_ra_ff - 1'b1) & nmask);

endmodule

/* src/two_level_page_walk_lru_unit.sv */
// Two-level page walk with least-recently-used frame replacement.
// req_if carries one access (process_id, virtual_addr); rsp_if returns one
// result per access (hit, table_created, evicted, physical_addr). Both use
// valid/ready; a beat moves when both are high.
// csr_we/csr_index/csr_wdata write first_level_bits (index 0) and
// frame_bits_in_use (index 1); any write flushes all tables and the LRU ring.
// After reset and after every register write a directory clearing pass over
// all PROCS << MAX_DIR_BITS entries (4096 by default) runs; req_if.ready stays low.
// One access is handled at a time. The walk runs through the registered
// reads of directory, page entry, frame owner and the LRU link memories;
// on a fault, on a hit to the oldest frame and with a single frame the
// result follows them, while a hit that relinks a frame in the LRU list
// first does the three link writes of the relink.
// The result is held until rsp_if.ready; the next request is taken in the
// cycle after the result beat.
module two_level_page_walk_lru_unit #(
   parameter int PROCS        = twlru_pkg::PROCS,
   parameter int PAGE_BITS    = twlru_pkg::PAGE_BITS,
   parameter int VADDR_BITS   = twlru_pkg::VADDR_BITS,
   parameter int FRAME_BITS   = twlru_pkg::FRAME_BITS,
   parameter int MAX_DIR_BITS = twlru_pkg::MAX_DIR_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   twlru_req_if.sink                         req_if,
   twlru_rsp_if.source                       rsp_if,
   input  logic                              csr_we,
   input  logic [twlru_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [twlru_pkg::CFG_W-1:0]       csr_wdata
);

   localparam int VPN_BITS  = VADDR_BITS - PAGE_BITS;
   localparam int PID_W     = (PROCS > 1) ? $clog2(PROCS) : 1;
   localparam int DIR_AW    = PID_W + MAX_DIR_BITS;
   localparam int DIR_DEPTH = PROCS << MAX_DIR_BITS;
   localparam int PG_AW     = PID_W + VPN_BITS;
   localparam int PG_DEPTH  = PROCS << VPN_BITS;
   localparam int OWN_W     = PID_W + VPN_BITS;
   localparam int NF        = 1 << FRAME_BITS;
   localparam int DIR_LIM   = (MAX_DIR_BITS < VPN_BITS) ? MAX_DIR_BITS : VPN_BITS;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RD1   = 4'd2;
   localparam logic [3:0] S_RD2   = 4'd3;
   localparam logic [3:0] S_CHK   = 4'd4;
   localparam logic [3:0] S_L1    = 4'd5;
   localparam logic [3:0] S_L2    = 4'd6;
   localparam logic [3:0] S_W2    = 4'd7;
   localparam logic [3:0] S_W3    = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   function automatic logic [PID_W-1:0] pid_wrap(input logic [twlru_pkg::PID_IN_W-1:0] p);
      logic [7:0] v;
      v = 8'(p);
      for (int i = 0; i < 3; i++) begin
         if (v >= 8'(PROCS)) begin
            v = v - 8'(PROCS);
         end
      end
      return v[PID_W-1:0];
   endfunction

   logic [3:0]                    state_ff, state_in;
   logic [twlru_pkg::CFG_W-1:0]   cfl_ff, cfb_ff;
   logic [DIR_AW-1:0]             clr_ff;
   logic [FRAME_BITS-1:0]         oldest_ff;
   logic [PID_W-1:0]              pid_ff;
   logic [VPN_BITS-1:0]           vpn_ff;
   logic [PAGE_BITS-1:0]          off_ff;
   logic [DIR_AW-1:0]             dix_ff;
   logic                          dir_rd_ff;
   logic [FRAME_BITS-1:0]         pg_rd_ff;
   logic [OWN_W-1:0]              own_rd_ff;
   logic [NF-1:0]                 own_vld_ff;
   logic [FRAME_BITS-1:0]         f_ff, p_ff, q_ff, last_ff;
   logic                          hit_ff, cre_ff, evi_ff;

   logic                          dir_mem [DIR_DEPTH];
   logic [FRAME_BITS-1:0]         pg_mem  [PG_DEPTH];
   logic [OWN_W-1:0]              own_mem [NF];

   logic                          flush;
   logic [4:0]                    fl_raw, fl_eff;
   logic [5:0]                    dir_sh;
   logic [4:0]                    fb_eff;
   logic [16:0]                   nmask_wide;
   logic [FRAME_BITS-1:0]         nmask;
   logic [VPN_BITS-1:0]           req_vpn;
   logic [63:0]                   dir_wide;
   logic [PID_W-1:0]              req_pid;
   logic [FRAME_BITS-1:0]         ent_f, f_sel, last_sel;
   logic                          hit_now;
   logic                          req_fire, clr_done;
   logic [FRAME_BITS-1:0]         nxt_raddr, prv_raddr, nxt_rdata, prv_rdata;
   logic                          nxt_we, prv_we;
   logic [FRAME_BITS-1:0]         nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;
   logic [63:0]                   pa_wide;

   // power up with every page entry pointing at frame zero
   initial begin
      for (int i = 0; i < PG_DEPTH; i++) begin
         pg_mem[i] = '0;
      end
   end

   assign flush = csr_we && (csr_index == twlru_pkg::REG_FIRST_LEVEL
                             || csr_index == twlru_pkg::REG_FRAME_BITS);

   // clamp directory width to 1..min(MAX_DIR_BITS, VPN_BITS)
   assign fl_raw = {1'b0, cfl_ff};
   assign fl_eff = (fl_raw == 5'd0) ? 5'd1 : ((fl_raw > 5'(DIR_LIM)) ? 5'(DIR_LIM) : fl_raw);
   assign dir_sh = 6'(VPN_BITS) - {1'b0, fl_eff};

   assign fb_eff     = ({1'b0, cfb_ff} > 5'(FRAME_BITS)) ? 5'(FRAME_BITS) : {1'b0, cfb_ff};
   assign nmask_wide = (17'd1 << fb_eff) - 17'd1;
   assign nmask      = nmask_wide[FRAME_BITS-1:0];

   assign req_vpn  = req_if.virtual_addr[VADDR_BITS-1:PAGE_BITS];
   assign dir_wide = 64'(req_vpn) >> dir_sh;
   assign req_pid  = pid_wrap(req_if.process_id);

   assign req_fire = req_if.valid && req_if.ready;
   assign clr_done = (clr_ff == DIR_AW'(DIR_DEPTH - 1));

   // a page entry counts only while its frame still names this page as owner
   assign ent_f    = pg_rd_ff & nmask;
   assign hit_now  = dir_rd_ff && own_vld_ff[ent_f] && (own_rd_ff == {pid_ff, vpn_ff});
   assign f_sel    = hit_now ? ent_f : oldest_ff;
   assign last_sel = (q_ff == oldest_ff) ? p_ff : prv_rdata;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_done) state_in = S_IDLE;
         S_IDLE:  if (req_fire) state_in = S_RD1;
         S_RD1:   state_in = S_RD2;
         S_RD2:   state_in = S_CHK;
         S_CHK:   state_in = S_L1;
         S_L1: begin
            if (!hit_ff || nmask == '0 || f_ff == oldest_ff) begin
               state_in = S_OUT;
            end else begin
               state_in = S_L2;
            end
         end
         S_L2:    state_in = S_W2;
         S_W2:    state_in = S_W3;
         S_W3:    state_in = S_OUT;
         S_OUT:   if (rsp_if.ready) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
      if (flush) begin
         state_in = S_CLEAR;
      end
   end

   always_comb begin
      nxt_raddr = f_ff;
      prv_raddr = f_ff;
      nxt_we    = 1'b0;
      prv_we    = 1'b0;
      nxt_waddr = p_ff;
      nxt_wdata = q_ff;
      prv_waddr = q_ff;
      prv_wdata = p_ff;
      case (state_ff)
         S_CHK: begin
            nxt_raddr = f_sel;
            prv_raddr = f_sel;
         end
         S_L1: begin
            prv_raddr = oldest_ff;
         end
         S_L2: begin
            nxt_we = 1'b1;
            prv_we = 1'b1;
         end
         S_W2: begin
            nxt_we    = 1'b1;
            nxt_waddr = last_ff;
            nxt_wdata = f_ff;
            prv_we    = 1'b1;
            prv_waddr = f_ff;
            prv_wdata = last_ff;
         end
         S_W3: begin
            nxt_we    = 1'b1;
            nxt_waddr = f_ff;
            nxt_wdata = oldest_ff;
            prv_we    = 1'b1;
            prv_waddr = oldest_ff;
            prv_wdata = f_ff;
         end
         default: begin
            nxt_we = 1'b0;
         end
      endcase
   end

   twlru_lru #(
      .FRAME_BITS (FRAME_BITS)
   ) u_lru (
      .clock     (clock),
      .reset     (reset),
      .flush     (flush),
      .nmask     (nmask),
      .nxt_raddr (nxt_raddr),
      .prv_raddr (prv_raddr),
      .nxt_we    (nxt_we),
      .nxt_waddr (nxt_waddr),
      .nxt_wdata (nxt_wdata),
      .prv_we    (prv_we),
      .prv_waddr (prv_waddr),
      .prv_wdata (prv_wdata),
      .nxt_rdata (nxt_rdata),
      .prv_rdata (prv_rdata)
   );

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         cfl_ff     <= twlru_pkg::FIRST_LEVEL_RESET;
         cfb_ff     <= twlru_pkg::FRAME_BITS_RESET;
         clr_ff     <= '0;
         oldest_ff  <= '0;
         own_vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (flush) begin
            if (csr_index == twlru_pkg::REG_FIRST_LEVEL) begin
               cfl_ff <= csr_wdata;
            end else begin
               cfb_ff <= csr_wdata;
            end
            clr_ff     <= '0;
            oldest_ff  <= '0;
            own_vld_ff <= '0;
         end else begin
            if (state_ff == S_CLEAR) begin
               clr_ff <= clr_ff + 1'b1;
            end
            if (state_ff == S_CHK && !hit_now) begin
               own_vld_ff[oldest_ff] <= 1'b1;
            end
            if (state_ff == S_L1) begin
               if (!hit_ff) begin
                  oldest_ff <= nxt_rdata & nmask;
               end else if (nmask != '0 && f_ff == oldest_ff) begin
                  oldest_ff <= nxt_rdata;
               end
            end
         end
      end
   end

   // payload and memories
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pid_ff <= req_pid;
         vpn_ff <= req_vpn;
         off_ff <= req_if.virtual_addr[PAGE_BITS-1:0];
         dix_ff <= {req_pid, dir_wide[MAX_DIR_BITS-1:0]};
      end
      if (state_ff == S_RD1) begin
         dir_rd_ff <= dir_mem[dix_ff];
         pg_rd_ff  <= pg_mem[PG_AW'({pid_ff, vpn_ff})];
      end
      if (state_ff == S_RD2) begin
         own_rd_ff <= own_mem[ent_f];
      end
      if (state_ff == S_CLEAR) begin
         dir_mem[clr_ff] <= 1'b0;
      end else if (state_ff == S_CHK && !hit_now && !dir_rd_ff) begin
         dir_mem[dix_ff] <= 1'b1;
      end
      if (state_ff == S_CHK) begin
         f_ff   <= f_sel;
         hit_ff <= hit_now;
         cre_ff <= !hit_now && !dir_rd_ff;
         evi_ff <= !hit_now && own_vld_ff[oldest_ff];
         if (!hit_now) begin
            pg_mem[PG_AW'({pid_ff, vpn_ff})] <= oldest_ff;
            own_mem[oldest_ff]              <= {pid_ff, vpn_ff};
         end
      end
      if (state_ff == S_L1) begin
         p_ff <= prv_rdata;
         q_ff <= nxt_rdata;
      end
      if (state_ff == S_L2) begin
         last_ff <= last_sel;
      end
   end

   assign pa_wide = 64'({f_ff, off_ff});

   assign req_if.ready         = (state_ff == S_IDLE);
   assign rsp_if.valid         = (state_ff == S_OUT);
   assign rsp_if.hit           = hit_ff;
   assign rsp_if.table_created = cre_ff;
   assign rsp_if.evicted       = evi_ff;
   assign rsp_if.physical_addr = pa_wide[twlru_pkg::PADDR_W-1:0];

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready)
      else $error("request taken while a result is pending");

   a_hit_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.hit |-> !rsp_if.table_created && !rsp_if.evicted)
      else $error("hit result carries fault flags");

   a_oldest_range: assert property (@(posedge clock) disable iff (reset)
      (oldest_ff & ~nmask) == '0)
      else $error("oldest frame outside frames in use");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_if.ready)
      else $error("ready right after a request beat");

endmodule

/* sim/twlru_checker.sv */
`timescale 1ns / 1ps

module twlru_checker (
   input  logic                                clock,
   input  logic                                reset,
   twlru_req_if                                req,
   twlru_rsp_if                                rsp,
   input  logic                                csr_we,
   input  logic [twlru_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [twlru_pkg::CFG_W-1:0]         csr_wdata,
   output int                                  errors,
   output int                                  pending
);

   localparam int VPN_W   = twlru_pkg::VADDR_BITS - twlru_pkg::PAGE_BITS;
   localparam int NFR     = 1 << twlru_pkg::FRAME_BITS;
   localparam int PIDW    = $clog2(twlru_pkg::PROCS);
   localparam int FRW     = twlru_pkg::FRAME_BITS;

   typedef struct packed {
      logic                           hit;
      logic                           table_created;
      logic                           evicted;
      logic [twlru_pkg::PADDR_W-1:0]  physical_addr;
   } walk_result_type;

   walk_result_type                 walk_q[$];
   logic [twlru_pkg::CFG_W-1:0]     dir_width_reg;
   logic [twlru_pkg::CFG_W-1:0]     frame_width_reg;
   bit                              dir_valid[twlru_pkg::PROCS << twlru_pkg::MAX_DIR_BITS];
   bit [FRW-1:0]                    page_map[bit [PIDW+VPN_W-1:0]];
   bit                              frame_owned[NFR];
   bit [PIDW+VPN_W-1:0]             frame_page[NFR];
   int unsigned                     ring_next[NFR];
   int unsigned                     ring_prev[NFR];
   int unsigned                     oldest;

   function automatic int unsigned frame_count();
      return 1 << ((frame_width_reg > FRW) ? FRW : int'(frame_width_reg));
   endfunction

   function automatic void flush_tables();
      int unsigned n;
      n = frame_count();
      foreach (dir_valid[i]) dir_valid[i] = 0;
      page_map.delete();
      for (int i = 0; i < NFR; i++) begin
         frame_owned[i] = 0;
         frame_page[i] = '0;
         ring_next[i] = 0;
         ring_prev[i] = 0;
      end
      for (int unsigned i = 0; i < n; i++) begin
         ring_next[i] = (i + 1) & (n - 1);
         ring_prev[i] = (i + n - 1) & (n - 1);
      end
      oldest = 0;
   endfunction

   function automatic walk_result_type walk(logic [twlru_pkg::PID_IN_W-1:0] pid_in,
                                            logic [twlru_pkg::VADDR_BITS-1:0] va);
      walk_result_type       r;
      int unsigned           n, fl, pid, dix, f, p, q, o, last;
      bit [VPN_W-1:0]        vpn;
      bit [PIDW+VPN_W-1:0]   pix;
      n = frame_count();
      fl = int'(dir_width_reg);
      if (fl < 1) fl = 1;
      if (fl > twlru_pkg::MAX_DIR_BITS) fl = twlru_pkg::MAX_DIR_BITS;
      if (fl > VPN_W) fl = VPN_W;
      pid = pid_in % twlru_pkg::PROCS;
      vpn = va[twlru_pkg::VADDR_BITS-1:twlru_pkg::PAGE_BITS];
      dix = (pid << twlru_pkg::MAX_DIR_BITS) | (32'(vpn) >> (VPN_W - fl));
      pix = {pid[PIDW-1:0], vpn};
      r = '0;
      if (dir_valid[dix] && page_map.exists(pix)) begin
         r.hit = 1;
         f = page_map[pix] & (n - 1);
         if (n > 1) begin
            if (f == oldest) begin
               oldest = ring_next[f];
            end else begin
               p = ring_prev[f];
               q = ring_next[f];
               o = oldest;
               ring_next[p] = q;
               ring_prev[q] = p;
               last = ring_prev[o];
               ring_next[last] = f;
               ring_prev[f] = last;
               ring_next[f] = o;
               ring_prev[o] = f;
            end
         end
      end else begin
         f = oldest & (n - 1);
         if (frame_owned[f]) begin
            page_map.delete(frame_page[f]);
            r.evicted = 1;
         end
         if (!dir_valid[dix]) begin
            r.table_created = 1;
            dir_valid[dix] = 1;
         end
         page_map[pix] = f[FRW-1:0];
         frame_owned[f] = 1;
         frame_page[f] = pix;
         oldest = ring_next[f] & (n - 1);
      end
      r.physical_addr = twlru_pkg::PADDR_W'((f << twlru_pkg::PAGE_BITS)
                                            | va[twlru_pkg::PAGE_BITS-1:0]);
      return r;
   endfunction

   assign pending = walk_q.size();

   always @(posedge clock) begin
      walk_result_type want, got;
      if (reset) begin
         dir_width_reg = twlru_pkg::FIRST_LEVEL_RESET;
         frame_width_reg = twlru_pkg::FRAME_BITS_RESET;
         flush_tables();
         walk_q.delete();
         errors <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == twlru_pkg::REG_FIRST_LEVEL) dir_width_reg = csr_wdata;
            else if (csr_index == twlru_pkg::REG_FRAME_BITS) frame_width_reg = csr_wdata;
            flush_tables();
         end
         if (req.valid && req.ready)
            walk_q.push_back(walk(req.process_id, req.virtual_addr));
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.hit, rsp.table_created, rsp.evicted, rsp.physical_addr};
            if (walk_q.size() == 0) begin
               if (errors < 10) $display("checker: unexpected result beat %p", got);
               errors <= errors + 1;
            end else begin
               want = walk_q.pop_front();
               if (want !== got) begin
                  if (errors < 10) $display("checker: mismatch expected %p actual %p",
                                            want, got);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

   initial begin
      dir_width_reg = twlru_pkg::FIRST_LEVEL_RESET;
      frame_width_reg = twlru_pkg::FRAME_BITS_RESET;
      flush_tables();
   end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int STALL_LIMIT = 20000;

   logic                             clock = 0;
   logic                             reset = 1;
   logic                             csr_we = 0;
   logic [twlru_pkg::CSR_IDX_W-1:0]  csr_index = twlru_pkg::REG_FIRST_LEVEL;
   logic [twlru_pkg::CFG_W-1:0]      csr_wdata = '0;
   int                               errors, pending;
   bit                               quiet = 0;
   int                               stall_cycles = 0;
   logic [twlru_pkg::PID_IN_W-1:0]   pool_pid[$];
   logic [31:0]                      pool_va[$];

   twlru_req_if rq ();
   twlru_rsp_if rs ();

   initial begin
      rq.valid = 0;
      rq.process_id = '0;
      rq.virtual_addr = '0;
      rs.ready = 0;
   end

   always #1 clock = ~clock;

   two_level_page_walk_lru_unit u_dut (
      .clock(clock), .reset(reset), .req_if(rq), .rsp_if(rs),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   twlru_checker u_check (
      .clock(clock), .reset(reset), .req(rq), .rsp(rs),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending)
   );

   always @(posedge clock)
      rs.ready <= reset ? 1'b0 : (quiet || $urandom_range(99) >= 14);

   always @(posedge clock) begin
      if (reset || (rq.valid && rq.ready) || (rs.valid && rs.ready) || csr_we)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   task automatic send(logic [twlru_pkg::PID_IN_W-1:0] pid, logic [31:0] va);
      if (!quiet && $urandom_range(99) < 14) begin
         rq.valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      rq.valid <= 1;
      rq.process_id <= pid;
      rq.virtual_addr <= va;
      do @(posedge clock); while (!rq.ready);
   endtask

   task automatic drain();
      rq.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [twlru_pkg::CSR_IDX_W-1:0] idx,
                            logic [twlru_pkg::CFG_W-1:0] value);
      drain();
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic build_pool(int frames);
      int          size;
      logic [31:0] base;
      pool_pid.delete();
      pool_va.delete();
      size = $urandom_range(2, 2 * frames + 4);
      base = $urandom;
      for (int i = 0; i < size; i++) begin
         pool_pid.push_back(twlru_pkg::PID_IN_W'($urandom_range(0, 3)));
         if ($urandom_range(1)) pool_va.push_back(base ^ ($urandom_range(0, 63) << 12));
         else pool_va.push_back($urandom);
      end
   endtask

   task automatic random_run(int items, int frames);
      int k;
      build_pool(frames);
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(99) < 25) begin
            send(twlru_pkg::PID_IN_W'($urandom_range(0, 3)), $urandom);
         end else begin
            k = $urandom_range(0, pool_va.size() - 1);
            send(pool_pid[k], {pool_va[k][31:12], 12'($urandom)});
         end
      end
   endtask

   typedef struct {
      logic [twlru_pkg::CSR_IDX_W-1:0] idx;
      logic [twlru_pkg::CFG_W-1:0]     value;
      int                              frames;
   } setting_type;

   setting_type plan[11] = '{
      '{twlru_pkg::REG_FRAME_BITS, 4'd0, 1},    '{twlru_pkg::REG_FIRST_LEVEL, 4'd1, 1},
      '{twlru_pkg::REG_FRAME_BITS, 4'd1, 2},    '{twlru_pkg::REG_FIRST_LEVEL, 4'd0, 2},
      '{twlru_pkg::REG_FRAME_BITS, 4'd15, 256}, '{twlru_pkg::REG_FIRST_LEVEL, 4'd15, 256},
      '{twlru_pkg::REG_FRAME_BITS, 4'd3, 8},    '{twlru_pkg::REG_FIRST_LEVEL, 4'd4, 8},
      '{twlru_pkg::REG_FRAME_BITS, 4'd2, 4},    '{twlru_pkg::REG_FIRST_LEVEL, 4'd10, 4},
      '{twlru_pkg::REG_FRAME_BITS, 4'd8, 256}
   };

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;

      send(2'd0, 32'h0000_0000);
      send(2'd0, 32'h0000_0FFF);
      send(2'd3, 32'hFFFF_FFFF);
      send(2'd3, 32'hFFFF_F000);
      send(2'd1, 32'h0000_0000);
      send(2'd0, 32'h0000_1ABC);
      send(2'd2, 32'h8000_0000);
      send(2'd2, 32'h7FFF_FFFF);
      send(2'd0, 32'hFFFF_FFFF);
      send(2'd0, 32'h0000_0123);
      send(2'd3, 32'h5555_5555);
      send(2'd1, 32'hAAAA_AAAA);
      send(2'd3, 32'h5555_5AAA);
      random_run(120, 256);

      foreach (plan[p]) begin
         write_reg(plan[p].idx, plan[p].value);
         quiet = (p == 4);
         random_run(140, plan[p].frames);
      end
      quiet = 0;
      drain();

      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
